// ===== rtl/core/lbpc_pkg.sv =====
// Package for the LED blink pattern controller: widths, reset constants,
// register and command codes, payload structs and the hold duration table.
// No dependencies.
`default_nettype none

package lbpc_pkg;

  localparam int NumLedsDefault = 2;
  localparam int ReloadW        = 10;
  localparam int CodeW          = 4;
  localparam int PatternW       = 2 * CodeW;
  localparam int HoldW          = 7;
  localparam int CfgIdxW        = 2;
  localparam int CfgDataW       = 10;

  localparam logic [ReloadW-1:0] ReloadTicksRst   = 10'd20;
  localparam logic [CodeW-1:0]   AlwaysOffCodeRst = 4'd0;
  localparam logic [CodeW-1:0]   AlwaysOnCodeRst  = 4'd15;

  typedef enum logic [CfgIdxW-1:0] {
    CfgReloadTicks   = 2'd0,
    CfgAlwaysOffCode = 2'd1,
    CfgAlwaysOnCode  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CmdTick = 1'b0,
    CmdSet  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic             command;
    logic             led_index;
    logic [CodeW-1:0] on_code;
    logic [CodeW-1:0] off_code;
    logic             apply_now;
  } in_item_t;

  typedef struct packed {
    logic led0_lit;
    logic led1_lit;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [ReloadW-1:0] reload_ticks;
    logic [CodeW-1:0]   always_off_code;
    logic [CodeW-1:0]   always_on_code;
  } cfg_t;

  // Per-LED command, already qualified by the accepted transaction.
  typedef struct packed {
    logic             tick;
    logic             set;
    logic             apply_now;
    logic [CodeW-1:0] on_code;
    logic [CodeW-1:0] off_code;
  } led_ctl_t;

  function automatic logic [HoldW-1:0] hold_duration(input logic [CodeW-1:0] code);
    logic [HoldW-1:0] dur;
    case (code)
      4'd0:    dur = 7'd0;
      4'd1:    dur = 7'd1;
      4'd2:    dur = 7'd2;
      4'd3:    dur = 7'd4;
      4'd4:    dur = 7'd6;
      4'd5:    dur = 7'd10;
      4'd6:    dur = 7'd16;
      4'd7:    dur = 7'd20;
      4'd8:    dur = 7'd24;
      4'd9:    dur = 7'd30;
      4'd10:   dur = 7'd36;
      4'd11:   dur = 7'd40;
      4'd12:   dur = 7'd50;
      4'd13:   dur = 7'd60;
      4'd14:   dur = 7'd100;
      default: dur = 7'h1F;
    endcase
    return dur;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lbpc_chan_if.sv =====
// Valid/ready channel interface used for the input, result and config ports.
// Payload type is a parameter; the structs come from lbpc_pkg.
`default_nettype none

interface lbpc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lbpc_led.sv =====
// State and update logic of one LED: reload timer, hold counter, patterns.
// Depends on lbpc_pkg.
`default_nettype none

module lbpc_led (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lbpc_pkg::led_ctl_t ctl_i,
  input  wire lbpc_pkg::cfg_t     cfg_i,
  output logic                   lit_o
);

  logic                             lit_q, lit_d;
  logic [lbpc_pkg::HoldW-1:0]       hold_q, hold_d;
  logic [lbpc_pkg::ReloadW-1:0]     reload_q, reload_d;
  logic [lbpc_pkg::PatternW-1:0]    active_q, active_d;
  logic [lbpc_pkg::PatternW-1:0]    pending_q, pending_d;
  logic [lbpc_pkg::ReloadW-1:0]     reload_dec;
  logic [lbpc_pkg::PatternW-1:0]    set_pattern;
  logic [lbpc_pkg::CodeW-1:0]       on_c, off_c;

  assign reload_dec  = reload_q - 1'b1;
  assign set_pattern = {ctl_i.on_code, ctl_i.off_code};
  assign on_c        = active_d[lbpc_pkg::PatternW-1:lbpc_pkg::CodeW];
  assign off_c       = active_d[lbpc_pkg::CodeW-1:0];

  always_comb begin
    lit_d     = lit_q;
    hold_d    = hold_q;
    reload_d  = reload_q;
    active_d  = active_q;
    pending_d = pending_q;
    if (ctl_i.tick) begin
      // Advance the reload timer; on expiry take the pending pattern.
      if (reload_dec == '0) begin
        reload_d = cfg_i.reload_ticks;
        active_d = pending_q;
      end else begin
        reload_d = reload_dec;
      end
      if (hold_q != '0) begin
        hold_d = hold_q - 1'b1;
      end else if (off_c == cfg_i.always_off_code) begin
        lit_d = 1'b0;
      end else if (on_c == cfg_i.always_on_code) begin
        lit_d = 1'b1;
      end else if (lit_q) begin
        hold_d = lbpc_pkg::hold_duration(off_c);
        lit_d  = 1'b0;
      end else begin
        hold_d = lbpc_pkg::hold_duration(on_c);
        lit_d  = 1'b1;
      end
    end else if (ctl_i.set) begin
      pending_d = set_pattern;
      if (ctl_i.apply_now) begin
        active_d = set_pattern;
        reload_d = lbpc_pkg::ReloadW'(1);
        hold_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q     <= 1'b0;
      hold_q    <= '0;
      reload_q  <= lbpc_pkg::ReloadTicksRst;
      active_q  <= '0;
      pending_q <= '0;
    end else begin
      lit_q     <= lit_d;
      hold_q    <= hold_d;
      reload_q  <= reload_d;
      active_q  <= active_d;
      pending_q <= pending_d;
    end
  end

  // Next drive level, captured by the result register in the same cycle.
  assign lit_o = lit_d;

endmodule

`default_nettype wire

// ===== rtl/core/led_blink_pattern_controller_top.sv =====
// LED blink pattern controller, top level.
// A result is valid in the cycle after its command transaction is accepted.
// Throughput: one command per cycle while the sink takes results; set by the
// single result register and per-LED update logic that completes in one pass.
// Reset: rst_ni (async, active low) clears the LED state, loads the reload
// timers with the reset reload period and restores the config registers.
`default_nettype none

module led_blink_pattern_controller_top #(
  parameter int NUM_LEDS = lbpc_pkg::NumLedsDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  lbpc_chan_if.sink    in_i,
  lbpc_chan_if.source  out_o,
  lbpc_chan_if.sink    cfg_i
);

  lbpc_pkg::cfg_t      cfg_q;
  lbpc_pkg::in_item_t  in_item;
  lbpc_pkg::cfg_item_t cfg_item;
  lbpc_pkg::out_item_t out_q;
  logic                out_valid_q;
  logic                in_ready;
  logic                in_acc;
  logic                cfg_acc;
  logic [NUM_LEDS-1:0] lit_next;

  assign in_item  = in_i.payload;
  assign cfg_item = cfg_i.payload;

  // Config writes are always taken; an index past the register list is dropped.
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reload_ticks    <= lbpc_pkg::ReloadTicksRst;
      cfg_q.always_off_code <= lbpc_pkg::AlwaysOffCodeRst;
      cfg_q.always_on_code  <= lbpc_pkg::AlwaysOnCodeRst;
    end else if (cfg_acc) begin
      case (lbpc_pkg::cfg_idx_e'(cfg_item.index))
        lbpc_pkg::CfgReloadTicks:
          cfg_q.reload_ticks <= cfg_item.data[lbpc_pkg::ReloadW-1:0];
        lbpc_pkg::CfgAlwaysOffCode:
          cfg_q.always_off_code <= cfg_item.data[lbpc_pkg::CodeW-1:0];
        lbpc_pkg::CfgAlwaysOnCode:
          cfg_q.always_on_code <= cfg_item.data[lbpc_pkg::CodeW-1:0];
        default: ;
      endcase
    end
  end

  // Accept a new command whenever the result register is empty or is being
  // drained in this cycle, so commands can stream back to back.
  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid && in_ready;

  // One update slice per LED. A set command only reaches the LED it names;
  // an index with no LED behind it reaches none.
  for (genvar k = 0; k < NUM_LEDS; k++) begin : g_led
    lbpc_pkg::led_ctl_t ctl;

    assign ctl.tick      = in_acc && (in_item.command == lbpc_pkg::CmdTick);
    assign ctl.set       = in_acc && (in_item.command == lbpc_pkg::CmdSet) &&
                           (32'(in_item.led_index) == k);
    assign ctl.apply_now = in_item.apply_now;
    assign ctl.on_code   = in_item.on_code;
    assign ctl.off_code  = in_item.off_code;

    lbpc_led u_led (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .cfg_i  (cfg_q),
      .lit_o  (lit_next[k])
    );
  end

  // Result register: hold until the sink takes it, load on every accepted
  // command with the drive levels after that command's update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q.led0_lit <= lit_next[0];
      if (NUM_LEDS > 1) begin
        out_q.led1_lit <= lit_next[(NUM_LEDS > 1) ? 1 : 0];
      end else begin
        out_q.led1_lit <= 1'b0;
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/lbpc_checker.sv =====
// Port-level checker for the LED blink pattern controller, bound to the top.
// Depends on lbpc_chan_if ports of led_blink_pattern_controller_top.
`default_nettype none

module lbpc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // With the result register empty the block must take commands.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Every accepted command produces a result in the next cycle.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> out_valid)
    else $error("accepted command produced no result");

  // A drained result with no new command leaves the output empty.
  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule

bind led_blink_pattern_controller_top lbpc_checker u_lbpc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.payload)
);

`default_nettype wire

// ===== dv/lbpc_tb_pkg.sv =====
// Result checker for the LED blink pattern controller testbench.
// Tracks the per-LED blink state and checks LED levels in order.
// Depends on lbpc_pkg.
`timescale 1ns / 1ps

package lbpc_tb_pkg;
  import lbpc_pkg::*;

  class blink_checker;
    bit [HoldW-1:0]    phase_len   [16];
    bit                lit         [NumLedsDefault];
    bit [HoldW-1:0]    hold_left   [NumLedsDefault];
    bit [ReloadW-1:0]  reload_left [NumLedsDefault];
    bit [PatternW-1:0] active_pat  [NumLedsDefault];
    bit [PatternW-1:0] pending_pat [NumLedsDefault];
    bit [ReloadW-1:0]  reload_period;
    bit [CodeW-1:0]    off_forever;
    bit [CodeW-1:0]    on_forever;
    out_item_t         levels_due  [$];
    int unsigned       mismatches;

    function new();
      phase_len = '{7'd0, 7'd1, 7'd2, 7'd4, 7'd6, 7'd10, 7'd16, 7'd20,
                    7'd24, 7'd30, 7'd36, 7'd40, 7'd50, 7'd60, 7'd100, 7'd31};
      reload_period = ReloadTicksRst;
      off_forever   = AlwaysOffCodeRst;
      on_forever    = AlwaysOnCodeRst;
      for (int k = 0; k < NumLedsDefault; k++) begin
        lit[k]         = 1'b0;
        hold_left[k]   = '0;
        reload_left[k] = reload_period;
        active_pat[k]  = '0;
        pending_pat[k] = '0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(cfg_item_t w);
      case (w.index)
        CfgReloadTicks:   reload_period = w.data[ReloadW-1:0];
        CfgAlwaysOffCode: off_forever   = w.data[CodeW-1:0];
        CfgAlwaysOnCode:  on_forever    = w.data[CodeW-1:0];
        default: ;
      endcase
    endfunction

    // Advance one LED by one tick.
    function void tick_led(int k);
      bit [CodeW-1:0] on_c;
      bit [CodeW-1:0] off_c;
      reload_left[k] = reload_left[k] - 1'b1;
      if (reload_left[k] == '0) begin
        reload_left[k] = reload_period;
        active_pat[k]  = pending_pat[k];
      end
      if (hold_left[k] != '0) begin
        hold_left[k] = hold_left[k] - 1'b1;
        return;
      end
      on_c  = active_pat[k][PatternW-1:CodeW];
      off_c = active_pat[k][CodeW-1:0];
      if (off_c == off_forever) begin
        lit[k] = 1'b0;
      end else if (on_c == on_forever) begin
        lit[k] = 1'b1;
      end else if (lit[k]) begin
        hold_left[k] = phase_len[off_c];
        lit[k]       = 1'b0;
      end else begin
        hold_left[k] = phase_len[on_c];
        lit[k]       = 1'b1;
      end
    endfunction

    function void note_command(in_item_t c);
      out_item_t lv;
      int        k;
      if (cmd_e'(c.command) == CmdTick) begin
        for (int j = 0; j < NumLedsDefault; j++) tick_led(j);
      end else if (int'(c.led_index) < NumLedsDefault) begin
        k = int'(c.led_index);
        if (c.apply_now) begin
          active_pat[k]  = {c.on_code, c.off_code};
          reload_left[k] = ReloadW'(1);
          hold_left[k]   = '0;
        end
        pending_pat[k] = {c.on_code, c.off_code};
      end
      lv.led0_lit = lit[0];
      lv.led1_lit = lit[1];
      levels_due.push_back(lv);
    endfunction

    function void check_levels(out_item_t got);
      out_item_t want;
      if (levels_due.size() == 0) begin
        $error("LED levels %b/%b arrived with none expected", got.led0_lit, got.led1_lit);
        mismatches++;
        return;
      end
      want = levels_due.pop_front();
      if (got.led0_lit !== want.led0_lit) begin
        $error("led0_lit: expected %0b, got %0b", want.led0_lit, got.led0_lit);
        mismatches++;
      end
      if (got.led1_lit !== want.led1_lit) begin
        $error("led1_lit: expected %0b, got %0b", want.led1_lit, got.led1_lit);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== dv/tb_top.sv =====
// Top-level testbench for led_blink_pattern_controller_top: directed and random
// commands under random idling on both channels, checked by blink_checker.
// Depends on lbpc_pkg, lbpc_chan_if and lbpc_tb_pkg.
`timescale 1ns / 1ps

module tb_top;
  import lbpc_pkg::*;
  import lbpc_tb_pkg::*;

  localparam int HalfPeriod = 5;
  // Leave a wide margin over the slowest correct run.
  localparam int CycleLimit = 400000;
  // Index past the register list; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Idle percentages for the command sender and the LED level receiver.
  int src_idle_pct = 16;
  int snk_idle_pct = 58;

  blink_checker chk = new();

  lbpc_chan_if #(.payload_t(in_item_t))  cmd_if ();
  lbpc_chan_if #(.payload_t(out_item_t)) led_if ();
  lbpc_chan_if #(.payload_t(cfg_item_t)) cfg_if ();

  led_blink_pattern_controller_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (led_if),
    .cfg_i  (cfg_if)
  );

  always #HalfPeriod clk = ~clk;

  // Receiver: decide ready once per falling edge, so stalls land anywhere.
  always @(negedge clk) begin
    led_if.ready = ($urandom_range(99) >= snk_idle_pct);
  end

  // Monitor: sample every handshake at the rising edge. Note commands before
  // checking results so that a same-cycle result would still find its entry.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) chk.write_reg(cfg_if.payload);
      if (cmd_if.valid && cmd_if.ready) chk.note_command(cmd_if.payload);
      if (led_if.valid && led_if.ready) chk.check_levels(led_if.payload);
    end
  end

  // Watchdog: end a hung run.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic in_item_t make_cmd(cmd_e op, logic idx, logic [CodeW-1:0] on_c,
                                        logic [CodeW-1:0] off_c, logic apply);
    in_item_t c;
    c.command   = op;
    c.led_index = idx;
    c.on_code   = on_c;
    c.off_code  = off_c;
    c.apply_now = apply;
    return c;
  endfunction

  // Present one command, idling at random first, and hold it until accepted.
  // Valid stays high afterward; the next call or drain() decides its level.
  task automatic send_cmd(input in_item_t c);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid = 1'b0;
      @(negedge clk);
    end
    cmd_if.valid   = 1'b1;
    cmd_if.payload = c;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  // Drop valid and wait until every expected LED level has arrived, then
  // give the pipeline a little slack.
  task automatic drain();
    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (chk.levels_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_if.valid   = 1'b1;
    cfg_if.payload = '{index: idx, data: data};
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Reprogram all registers on an idle block. Code registers get random
  // upper data bits, which the block must ignore.
  task automatic program_regs(input logic [ReloadW-1:0] period, input logic [CodeW-1:0] off_c,
                              input logic [CodeW-1:0] on_c);
    logic [CfgDataW-1:0] word;
    drain();
    write_reg(CfgReloadTicks, period);
    word = CfgDataW'($urandom);
    word[CodeW-1:0] = off_c;
    write_reg(CfgAlwaysOffCode, word);
    word = CfgDataW'($urandom);
    word[CodeW-1:0] = on_c;
    write_reg(CfgAlwaysOnCode, word);
  endtask

  // Random commands: mostly ticks so patterns actually blink and reload,
  // with set commands of random content mixed in. Pause once midway until
  // the block has caught up.
  task automatic run_random(input int n, input int tick_pct);
    in_item_t c;
    for (int i = 0; i < n; i++) begin
      c.command   = ($urandom_range(99) < tick_pct) ? CmdTick : CmdSet;
      c.led_index = 1'($urandom);
      c.on_code   = CodeW'($urandom);
      c.off_code  = CodeW'($urandom);
      c.apply_now = 1'($urandom);
      send_cmd(c);
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    logic [CodeW-1:0] code;

    // Drive every input to a known level before the first edge.
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    led_if.ready   = 1'b0;

    // Hold reset, then release it away from the sampling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, reset configuration.
    // Zero pattern: off code equals the always-off code, LED stays dark.
    send_cmd(make_cmd(CmdTick, 1'b0, 4'h0, 4'h0, 1'b0));
    // A tick ignores whatever sits in the set fields.
    send_cmd(make_cmd(CmdTick, 1'b1, 4'hF, 4'hF, 1'b1));
    // Always-on pattern applied at once; the level changes only on the tick.
    send_cmd(make_cmd(CmdSet, 1'b0, 4'hF, 4'hF, 1'b1));
    send_cmd(make_cmd(CmdTick, 1'b0, 4'h0, 4'h0, 1'b0));
    // Pending only: LED 1 must not react yet.
    send_cmd(make_cmd(CmdSet, 1'b1, 4'h1, 4'h2, 1'b0));
    send_cmd(make_cmd(CmdTick, 1'b0, 4'h0, 4'h0, 1'b0));
    // Toggling pattern: short on-time, longest table off-time.
    send_cmd(make_cmd(CmdSet, 1'b1, 4'h3, 4'hE, 1'b1));
    repeat (6) send_cmd(make_cmd(CmdTick, 1'b0, 4'h0, 4'h0, 1'b0));
    // Zero on-time entry: LED 0 toggles with no hold while on.
    send_cmd(make_cmd(CmdSet, 1'b0, 4'h0, 4'hF, 1'b1));
    repeat (3) send_cmd(make_cmd(CmdTick, 1'b0, 4'h0, 4'h0, 1'b0));
    // Always-off beats always-on when both codes match.
    send_cmd(make_cmd(CmdSet, 1'b0, 4'hF, 4'h0, 1'b1));
    // Queue a pattern for LED 1 to be picked up by the reload timer.
    send_cmd(make_cmd(CmdSet, 1'b1, 4'hE, 4'h1, 1'b0));
    repeat (4) send_cmd(make_cmd(CmdTick, 1'b0, 4'h0, 4'h0, 1'b0));

    // Sender idles lightly, receiver heavily.
    run_random(230, 75);

    // Shortest reload period, code registers at the opposite extremes, and a
    // write to an unmapped index that must change nothing.
    program_regs(10'd1, 4'hF, 4'h0);
    write_reg(CfgUnmapped, CfgDataW'($urandom));
    run_random(200, 75);

    // Swap the idling: sender stalls often, receiver rarely.
    src_idle_pct = 58;
    snk_idle_pct = 16;
    program_regs(10'd1023, 4'h0, 4'hF);
    run_random(220, 80);

    // Zero reload period: the counter wraps and copies 1024 ticks later.
    program_regs(10'd0, CodeW'($urandom), CodeW'($urandom));
    run_random(260, 90);

    // No idling on either side from here on.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    code = CodeW'($urandom);
    program_regs(ReloadW'($urandom_range(2, 60)), code, code);
    run_random(220, 75);

    program_regs(ReloadW'($urandom_range(1, 1023)), CodeW'($urandom), CodeW'($urandom));
    run_random(230, 75);

    // Let the last results drain, then report.
    drain();
    if (chk.mismatches == 0 && chk.levels_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
